// ----- hw/rtl/cssg_pkg.sv -----
// cssg_pkg: shared types and constants for the cycle signature successor generator
// no dependencies; used by cycle_signature_successor_generator
package cssg_pkg;

  localparam int SIG_W       = 64;
  localparam int MAX_SYMBOLS = 32;
  localparam int WIDTH_W     = 5;
  localparam int DEPTH_W     = 7;

  // symbol codes
  localparam logic [1:0] SYM_A = 2'b00;
  localparam logic [1:0] SYM_B = 2'b01;
  localparam logic [1:0] SYM_O = 2'b10;
  localparam logic [1:0] SYM_X = 2'b11;

  // scan jobs, in the order they are run
  localparam logic [1:0] SCAN_APB0 = 2'd0;  // partner of bottom B, start depth 0
  localparam logic [1:0] SCAN_APBM = 2'd1;  // partner of second-bottom B, start depth -1
  localparam logic [1:0] SCAN_BPA  = 2'd2;  // partner of top A in the signature
  localparam logic [1:0] SCAN_BPAN = 2'd3;  // partner of top A after the first rewrite

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ----- hw/rtl/cycle_signature_successor_generator.sv -----
// cycle_signature_successor_generator: top level, bracket scans and successor emission
// depends on cssg_pkg
//
// Usage:
//   A signature word is taken when start is high and busy is low. busy stays high
//   until the last successor of that word has been registered; that successor is
//   shown in the first cycle with busy low, when a new word may already be taken.
//   Successors appear on successor, successor_index and last, each for exactly one
//   cycle while result_valid is high; the receiver cannot stall, so every word is
//   taken the cycle it is shown.
//   width_in_use is written through cfg_valid/cfg_ready/cfg_data (ready always high);
//   it must be written by the user only while busy is low; the block does not enforce this.
// Timing:
//   Four bracket scans run one after the other, one symbol per cycle through a
//   shift register, each stopping at the partner or after width_in_use+1 symbols,
//   with a load state ahead of each. Then one successor per cycle is shown.
//   An invalid signature gives no successor and returns to idle from the emit
//   state after the scans.
// Reset:
//   rst (synchronous, active high) returns to idle and sets width_in_use to 31.
module cycle_signature_successor_generator #(
  parameter int MAX_SYMBOLS = cssg_pkg::MAX_SYMBOLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [cssg_pkg::SIG_W-1:0]  signature,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cssg_pkg::WIDTH_W-1:0] cfg_data,
  output logic                        result_valid,
  output logic [cssg_pkg::SIG_W-1:0]  successor,
  output logic [1:0]                  successor_index,
  output logic                        last
);

  localparam int SW = cssg_pkg::SIG_W;
  localparam int WW = cssg_pkg::WIDTH_W;
  localparam int DW = cssg_pkg::DEPTH_W;
  localparam logic [WW-1:0] W_MAX = WW'(MAX_SYMBOLS - 1);

  cssg_pkg::state_t state, state_next;

  logic [WW-1:0]        width_in_use;
  logic [WW-1:0]        w_eff;
  logic [SW-1:0]        sig;
  logic [SW-1:0]        sreg;
  logic [SW-1:0]        src;
  logic [SW-1:0]        apb0, apbm, bpa, bpan;
  logic                 closes;
  logic signed [DW-1:0] depth;
  logic [WW-1:0]        cnt;
  logic [1:0]           sel;
  logic [1:0]           eidx;
  logic                 valid_sig;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= WW'(31);
    end else if (cfg_valid && cfg_ready) begin
      width_in_use <= cfg_data;
    end
  end

  assign w_eff = (width_in_use > W_MAX) ? W_MAX : width_in_use;
  assign busy  = (state != cssg_pkg::ST_IDLE);

  // input masking above the top symbol
  logic [SW-1:0] in_mask;
  logic [6:0]    mask_sh;
  assign mask_sh = {1'b0, w_eff, 1'b0} + 7'd2;
  assign in_mask = (w_eff < WW'(31)) ? ~({SW{1'b1}} << mask_sh) : {SW{1'b1}};

  // validity: bottom not O and some A or B within range
  always_comb begin
    logic any_ab;
    any_ab = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (WW'(i) <= w_eff && !sig[2*i+1]) any_ab = 1'b1;
    end
    valid_sig = any_ab && (sig[1:0] != cssg_pkg::SYM_O);
  end

  // scan step
  logic          up;
  logic [1:0]    sym;
  logic [WW-1:0] pos;
  logic signed [DW-1:0] depth_new;
  logic          hit;
  logic          scan_end;
  logic [SW-1:0] scan_res;

  assign up  = (sel == cssg_pkg::SCAN_APB0) || (sel == cssg_pkg::SCAN_APBM);
  assign src = (sel == cssg_pkg::SCAN_BPAN) ? apb0 : sig;
  assign sym = up ? sreg[1:0] : sreg[SW-1:SW-2];
  assign pos = up ? cnt : (w_eff - cnt);

  always_comb begin
    logic [1:0] opn, cls;
    opn = up ? cssg_pkg::SYM_B : cssg_pkg::SYM_A;
    cls = up ? cssg_pkg::SYM_A : cssg_pkg::SYM_B;
    depth_new = depth;
    hit = 1'b0;
    if (sym == opn) begin
      depth_new = depth + DW'(1);
    end else if (sym == cls) begin
      depth_new = depth - DW'(1);
      hit = (depth_new == '0);
    end
  end

  assign scan_end = hit || (cnt == w_eff);
  assign scan_res = hit ? (src ^ (SW'(1) << {pos, 1'b0})) : src;

  // weights at the top symbol
  logic [SW-1:0] bx, bo, bb, bx4, bo4, bb4, sh;
  logic [1:0]    t, s1, s0;
  assign bx  = SW'(3) << {w_eff, 1'b0};
  assign bo  = SW'(2) << {w_eff, 1'b0};
  assign bb  = SW'(1) << {w_eff, 1'b0};
  assign bx4 = bx >> 2;
  assign bo4 = bo >> 2;
  assign bb4 = bb >> 2;
  assign sh  = sig >> 2;
  assign t   = sig[{w_eff, 1'b0} +: 2];
  assign s1  = sig[3:2];
  assign s0  = sig[1:0];

  // successor list: base and addend per slot
  logic [SW-1:0] base [4];
  logic [SW-1:0] addn [4];
  logic [2:0]    n;
  always_comb begin
    logic [SW-1:0] q;
    logic [2:0]    k;
    q = apb0 >> 2;
    k = 3'd0;
    for (int i = 0; i < 4; i++) begin
      base[i] = '0;
      addn[i] = '0;
    end
    if (valid_sig && s0 == cssg_pkg::SYM_X && t != cssg_pkg::SYM_B) begin
      case (s1)
        cssg_pkg::SYM_X: begin
          if (t == cssg_pkg::SYM_O) begin
            base[k[1:0]] = sh; addn[k[1:0]] = -bb4; k = k + 3'd1;
          end else if (t == cssg_pkg::SYM_A) begin
            base[k[1:0]] = sh; addn[k[1:0]] = bx4; k = k + 3'd1;
          end
          base[k[1:0]] = sh; addn[k[1:0]] = bo; k = k + 3'd1;
        end
        cssg_pkg::SYM_O: begin
          base[0] = sh; addn[0] = -SW'(1); k = 3'd1;
          if (t == cssg_pkg::SYM_O) begin
            base[1] = sh; addn[1] = bx - bo4 - SW'(1); k = 3'd2;
          end else if (t == cssg_pkg::SYM_A) begin
            base[1] = bpa >> 2; addn[1] = bx + bx4 - SW'(1); k = 3'd2;
          end
        end
        cssg_pkg::SYM_B: begin
          if (t == cssg_pkg::SYM_X) begin
            base[0] = sh; addn[0] = bo;
            base[1] = q;  addn[1] = SW'(2);
            k = 3'd2;
          end else if (t == cssg_pkg::SYM_O) begin
            base[0] = sh; addn[0] = -bb4;
            base[1] = sh; addn[1] = bo;
            base[2] = q;  addn[2] = SW'(2);
            base[3] = q;  addn[3] = bx - bo4 + SW'(2);
            k = 3'd4;
          end else begin
            base[0] = sh; addn[0] = bx4;
            base[1] = sh; addn[1] = bo;
            base[2] = q;  addn[2] = SW'(2);
            k = 3'd3;
            if (!closes) begin
              base[3] = bpan >> 2; addn[3] = bx + bx4 + SW'(2); k = 3'd4;
            end
          end
        end
        default: k = 3'd0;
      endcase
    end else if (valid_sig && s0 == cssg_pkg::SYM_B && t != cssg_pkg::SYM_B) begin
      case (s1)
        cssg_pkg::SYM_X, cssg_pkg::SYM_B: begin
          base[0] = q; addn[0] = '0; k = 3'd1;
          if (t == cssg_pkg::SYM_O) begin
            base[1] = q; addn[1] = bx - bo4; k = 3'd2;
          end else if (t == cssg_pkg::SYM_A && !closes) begin
            base[1] = bpan >> 2; addn[1] = bx + bx4; k = 3'd2;
          end
          if (s1 == cssg_pkg::SYM_B) begin
            base[k[1:0]] = apbm >> 2; addn[k[1:0]] = bx + SW'(2); k = k + 3'd1;
          end
        end
        cssg_pkg::SYM_O: begin
          base[0] = sh; addn[0] = bx - SW'(1); k = 3'd1;
        end
        default: begin
          base[0] = sh; addn[0] = SW'(1); k = 3'd1;
          if (t == cssg_pkg::SYM_O) begin
            base[1] = sh; addn[1] = bx - bo4 + SW'(1); k = 3'd2;
          end else if (t == cssg_pkg::SYM_A) begin
            base[1] = bpa >> 2; addn[1] = bx + bx4 + SW'(1); k = 3'd2;
          end
        end
      endcase
    end
    n = k;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= cssg_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cssg_pkg::ST_IDLE: if (start) state_next = cssg_pkg::ST_LOAD;
      cssg_pkg::ST_LOAD: state_next = cssg_pkg::ST_SCAN;
      cssg_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = (sel == cssg_pkg::SCAN_BPAN) ? cssg_pkg::ST_EMIT : cssg_pkg::ST_LOAD;
        end
      end
      cssg_pkg::ST_EMIT: begin
        if ({1'b0, eidx} + 3'd1 >= n) state_next = cssg_pkg::ST_IDLE;
      end
      default: state_next = cssg_pkg::ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sel          <= cssg_pkg::SCAN_APB0;
      eidx         <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        cssg_pkg::ST_IDLE: begin
          sel  <= cssg_pkg::SCAN_APB0;
          eidx <= 2'd0;
        end
        cssg_pkg::ST_SCAN: if (scan_end) sel <= sel + 2'd1;
        cssg_pkg::ST_EMIT: begin
          if ({1'b0, eidx} < n) result_valid <= 1'b1;
          eidx <= eidx + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cssg_pkg::ST_IDLE: if (start) sig <= signature & in_mask;
      cssg_pkg::ST_LOAD: begin
        sreg  <= up ? src : (src << {WW'(31) - w_eff, 1'b0});
        depth <= (sel == cssg_pkg::SCAN_APBM) ? -DW'(1) : '0;
        cnt   <= '0;
      end
      cssg_pkg::ST_SCAN: begin
        sreg  <= up ? (sreg >> 2) : (sreg << 2);
        depth <= depth_new;
        cnt   <= cnt + WW'(1);
        if (scan_end) begin
          case (sel)
            cssg_pkg::SCAN_APB0: begin
              apb0   <= scan_res;
              closes <= !hit || (pos == w_eff);
            end
            cssg_pkg::SCAN_APBM: apbm <= scan_res;
            cssg_pkg::SCAN_BPA:  bpa  <= scan_res;
            default:             bpan <= scan_res;
          endcase
        end
      end
      cssg_pkg::ST_EMIT: begin
        successor       <= base[eidx] + addn[eidx];
        successor_index <= eidx;
        last            <= ({1'b0, eidx} + 3'd1 == n);
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for cycle_signature_successor_generator
// depends on cssg_pkg and the block's rtl; directed and random signatures, several widths
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [cssg_pkg::SIG_W-1:0] succ;
    logic [1:0]                 idx;
    logic                       fin;
  } succ_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic [cssg_pkg::SIG_W-1:0]     signature = '0;
  logic                           cfg_valid = 1'b0;
  logic [cssg_pkg::WIDTH_W-1:0]   cfg_data = '0;
  logic                           busy, cfg_ready, result_valid, last;
  logic [cssg_pkg::SIG_W-1:0]     successor;
  logic [1:0]                     successor_index;

  succ_word_t           succ_q[$];
  int                   width_now = 31;
  int                   n_errors = 0;
  int                   n_words = 0;
  int                   n_results = 0;

  cycle_signature_successor_generator u_dut (
    .clk, .rst, .start, .busy, .signature, .cfg_valid, .cfg_ready, .cfg_data,
    .result_valid, .successor, .successor_index, .last
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // symbol access at one slot
  function automatic logic [1:0] sym(logic [cssg_pkg::SIG_W-1:0] s, int pos);
    return s[2*pos +: 2];
  endfunction

  // the B partnering the top A becomes A
  function automatic logic [cssg_pkg::SIG_W-1:0] top_a_partner_to_a(
      logic [cssg_pkg::SIG_W-1:0] s, int w);
    int depth;
    depth = 0;
    for (int i = 0; i <= w && i < cssg_pkg::MAX_SYMBOLS; i++) begin
      if (sym(s, w - i) == cssg_pkg::SYM_A) depth++;
      else if (sym(s, w - i) == cssg_pkg::SYM_B) begin
        depth--;
        if (depth == 0) return s & ~(64'd1 << (2 * (w - i)));
      end
    end
    return s;
  endfunction

  // scan up from the bottom, the matching A becomes B
  function automatic logic [cssg_pkg::SIG_W-1:0] bottom_b_partner_to_b(
      logic [cssg_pkg::SIG_W-1:0] s, int depth, int w);
    for (int i = 0; i <= w && i < cssg_pkg::MAX_SYMBOLS; i++) begin
      if (sym(s, i) == cssg_pkg::SYM_B) depth++;
      else if (sym(s, i) == cssg_pkg::SYM_A) begin
        depth--;
        if (depth == 0) return s + (64'd1 << (2 * i));
      end
    end
    return s;
  endfunction

  // partner of the bottom B is the top symbol, or missing
  function automatic bit bottom_b_closes(logic [cssg_pkg::SIG_W-1:0] s, int w);
    int depth;
    int found;
    depth = 0;
    found = 0;
    for (int i = 0; i <= w && i < cssg_pkg::MAX_SYMBOLS; i++) begin
      if (sym(s, i) == cssg_pkg::SYM_B) depth++;
      else if (sym(s, i) == cssg_pkg::SYM_A) begin
        depth--;
        if (depth == 0) begin
          found = w - i;
          break;
        end
      end
    end
    return found == 0;
  endfunction

  // work out the successor words of one signature and queue them
  task automatic queue_successors(logic [cssg_pkg::SIG_W-1:0] sig);
    logic [cssg_pkg::SIG_W-1:0] s, sh, bx, bo, bb, q, nb;
    logic [cssg_pkg::SIG_W-1:0] r[$];
    logic [1:0] t, s1, s0;
    bit ok;
    int w;
    w = (width_now > cssg_pkg::MAX_SYMBOLS - 1) ? cssg_pkg::MAX_SYMBOLS - 1 : width_now;
    s = sig;
    if (w < 31) s &= (64'd1 << (2 * w + 2)) - 64'd1;
    ok = 0;
    for (int i = 0; i <= w && i < cssg_pkg::MAX_SYMBOLS; i++)
      if (sym(s, i) == cssg_pkg::SYM_A || sym(s, i) == cssg_pkg::SYM_B) ok = 1;
    if (sym(s, 0) == cssg_pkg::SYM_O) ok = 0;
    if (ok) begin
      bx = 64'd3 << (2 * w);
      bo = 64'd2 << (2 * w);
      bb = 64'd1 << (2 * w);
      sh = s >> 2;
      t  = sym(s, w);
      s1 = sym(s, 1);
      s0 = sym(s, 0);
      if (s0 == cssg_pkg::SYM_X && t != cssg_pkg::SYM_B) begin
        if (s1 == cssg_pkg::SYM_X) begin
          if (t == cssg_pkg::SYM_O) r.push_back(sh - bb / 4);
          else if (t == cssg_pkg::SYM_A) r.push_back(sh + bx / 4);
          r.push_back(sh + bo);
        end else if (s1 == cssg_pkg::SYM_O) begin
          r.push_back(sh - 64'd1);
          if (t == cssg_pkg::SYM_O) r.push_back(sh + (bx - bo / 4 - 64'd1));
          else if (t == cssg_pkg::SYM_A)
            r.push_back((top_a_partner_to_a(s, w) >> 2) + (bx + bx / 4 - 64'd1));
        end else if (s1 == cssg_pkg::SYM_B) begin
          q = bottom_b_partner_to_b(s, 0, w) >> 2;
          if (t == cssg_pkg::SYM_X) begin
            r.push_back(sh + bo);
            r.push_back(q + 64'd2);
          end else if (t == cssg_pkg::SYM_O) begin
            r.push_back(sh - bb / 4);
            r.push_back(sh + bo);
            r.push_back(q + 64'd2);
            r.push_back(q + (bx - bo / 4 + 64'd2));
          end else begin
            r.push_back(sh + bx / 4);
            r.push_back(sh + bo);
            r.push_back(q + 64'd2);
            if (!bottom_b_closes(s, w))
              r.push_back((top_a_partner_to_a(bottom_b_partner_to_b(s, 0, w), w) >> 2)
                          + (bx + bx / 4 + 64'd2));
          end
        end
      end else if (s0 == cssg_pkg::SYM_B && t != cssg_pkg::SYM_B) begin
        if (s1 == cssg_pkg::SYM_X || s1 == cssg_pkg::SYM_B) begin
          nb = bottom_b_partner_to_b(s, 0, w);
          q = nb >> 2;
          r.push_back(q);
          if (t == cssg_pkg::SYM_O) r.push_back(q + (bx - bo / 4));
          else if (t == cssg_pkg::SYM_A && !bottom_b_closes(s, w))
            r.push_back((top_a_partner_to_a(nb, w) >> 2) + (bx + bx / 4));
          if (s1 == cssg_pkg::SYM_B)
            r.push_back((bottom_b_partner_to_b(s, -1, w) >> 2) + (bx + 64'd2));
        end else if (s1 == cssg_pkg::SYM_O) begin
          r.push_back(sh + (bx - 64'd1));
        end else begin
          r.push_back(sh + 64'd1);
          if (t == cssg_pkg::SYM_O) r.push_back(sh + (bx - bo / 4 + 64'd1));
          else if (t == cssg_pkg::SYM_A)
            r.push_back((top_a_partner_to_a(s, w) >> 2) + (bx + bx / 4 + 64'd1));
        end
      end
    end
    foreach (r[k]) succ_q.push_back('{succ: r[k], idx: 2'(k), fin: (k == r.size() - 1)});
  endtask

  task automatic report(string what, logic [cssg_pkg::SIG_W-1:0] got,
                        logic [cssg_pkg::SIG_W-1:0] want);
    n_errors++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // check each successor word against the oldest expectation
  always @(posedge clk) begin
    succ_word_t e;
    if (!rst && result_valid) begin
      n_results++;
      if (succ_q.size() == 0) report("unexpected word", successor, '0);
      else begin
        e = succ_q.pop_front();
        if (successor !== e.succ) report("successor", successor, e.succ);
        if (successor_index !== e.idx)
          report("successor_index", cssg_pkg::SIG_W'(successor_index),
                 cssg_pkg::SIG_W'(e.idx));
        if (last !== e.fin)
          report("last", cssg_pkg::SIG_W'(last), cssg_pkg::SIG_W'(e.fin));
      end
    end
  end

  // send one signature; start stays high for a following word
  task automatic send_sig(logic [cssg_pkg::SIG_W-1:0] sig, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start     <= 1'b1;
    signature <= sig;
    do @(posedge clk); while (busy);
    n_words++;
    queue_successors(sig);
  endtask

  // drain all expectations and let a silent word run out
  task automatic settle();
    start <= 1'b0;
    while (succ_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4 * (width_now + 2) + 10) @(posedge clk);
  endtask

  task automatic write_width(int w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cssg_pkg::WIDTH_W'(w);
    do @(posedge clk); while (!cfg_ready);
    width_now = w;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random signature, bracket-balanced three times in four; high unused bits random
  function automatic logic [cssg_pkg::SIG_W-1:0] make_sig(int w);
    logic [cssg_pkg::SIG_W-1:0] s;
    int depth;
    int pick;
    s = {$urandom, $urandom};
    if ($urandom_range(99) < 25 || w > 31) return s;
    depth = 0;
    for (int i = w; i >= 0; i--) begin
      pick = $urandom_range(3);
      if (depth == i + 1) pick = cssg_pkg::SYM_B;
      else if (pick == cssg_pkg::SYM_B && depth == 0) pick = cssg_pkg::SYM_A;
      if (pick == cssg_pkg::SYM_A && depth + 1 > i) pick = cssg_pkg::SYM_X;
      if (pick == cssg_pkg::SYM_A) depth++;
      if (pick == cssg_pkg::SYM_B) depth--;
      s[2*i +: 2] = 2'(pick);
    end
    return s;
  endfunction

  // symbol extremes at full width
  task automatic test_extremes();
    send_sig('0, 0);
    send_sig('1, 0);
    send_sig({2'b00, {30{2'b11}}, 2'b01}, 0);
    send_sig({2'b10, {29{2'b10}}, 2'b01, 2'b11}, 0);
  endtask

  // every top (but B) / second-bottom combination, bottom X or B, at a narrow width
  task automatic test_cases();
    logic [1:0] mid;
    write_width(3);
    for (int t = 0; t < 4; t++)
      for (int b = 0; b < 4; b++)
        if (t != cssg_pkg::SYM_B) begin
          mid = (b == cssg_pkg::SYM_B) ? cssg_pkg::SYM_A : cssg_pkg::SYM_B;
          send_sig({{56{1'b1}}, 2'(t), mid, 2'(b), cssg_pkg::SYM_X}, 0);
          send_sig({{56{1'b0}}, 2'(t), mid, 2'(b), cssg_pkg::SYM_B}, 0);
        end
  endtask

  task automatic test_random(int w, int n, int gap_pct, bit hold_off);
    write_width(w);
    for (int i = 0; i < n; i++) begin
      if (hold_off && i == n / 2) begin
        start <= 1'b0;
        while (succ_q.size() != 0) @(posedge clk);
      end
      send_sig(make_sig(w), gap_pct);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_cases();
    test_random(31, 110, 18, 1'b0);
    test_random(2, 60, 76, 1'b1);
    test_random(0, 10, 18, 1'b0);
    test_random(1, 10, 76, 1'b0);
    test_random($urandom_range(3, 30), 70, 0, 1'b0);
    test_random(31, 60, 0, 1'b1);
    settle();
    $display("covered %0d signatures and %0d successor words over widths 0 to 31",
             n_words, n_results);
    $display("sender gaps at 18 and 76 in a hundred and none, with hold-offs until drained");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
